[rtl/core/integer_to_padded_text_defines.svh]
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_PADDED_TEXT_DEFINES_SVH
`define INTEGER_TO_PADDED_TEXT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/itpt_pkg.sv]
// Shared types, constants and character helpers for the integer formatter.
`timescale 1ns / 1ps
package itpt_pkg;

  localparam int NUM_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int DIG_REG_W  = 4 * BCD_DIGITS;
  localparam int DCNT_W     = 6;

  typedef logic [1:0] base_t;
  localparam base_t BASE_BIN = 2'd0;
  localparam base_t BASE_OCT = 2'd1;
  localparam base_t BASE_DEC = 2'd2;
  localparam base_t BASE_HEX = 2'd3;

  // Bit positions inside option_bits.
  localparam int OPT_ZERO   = 0;
  localparam int OPT_SIGNED = 1;
  localparam int OPT_PLUS   = 2;
  localparam int OPT_SPACE  = 3;
  localparam int OPT_LEFT   = 4;
  localparam int OPT_PREFIX = 5;
  localparam int OPT_LOWER  = 6;

  typedef logic [DCNT_W-1:0] dcnt_t;
  localparam dcnt_t DIGS_BIN = 6'd32;
  localparam dcnt_t DIGS_OCT = 6'd11;
  localparam dcnt_t DIGS_DEC = 6'd10;
  localparam dcnt_t DIGS_HEX = 6'd8;

  typedef logic [6:0] char_t;
  localparam char_t CH_SPACE = 7'h20;
  localparam char_t CH_PLUS  = 7'h2B;
  localparam char_t CH_MINUS = 7'h2D;
  localparam char_t CH_ZERO  = 7'h30;
  localparam char_t CH_UA    = 7'h41;
  localparam char_t CH_LA    = 7'h61;
  localparam char_t CH_B     = 7'h62;
  localparam char_t CH_O     = 7'h6F;
  localparam char_t CH_X     = 7'h78;

  // Commands from the sequencer to the digit shift register.
  typedef struct packed {
    logic load;
    logic shift;
  } dig_cmd_t;

  function automatic char_t digit_char(input logic [3:0] d, input logic lower);
    if (d < 4'd10) begin
      return CH_ZERO + char_t'(d);
    end
    return (lower ? CH_LA : CH_UA) + char_t'(d - 4'd10);
  endfunction

  function automatic char_t prefix_char(input base_t b);
    unique case (b)
      BASE_BIN: return CH_B;
      BASE_OCT: return CH_O;
      default:  return CH_X;
    endcase
  endfunction

endpackage

[rtl/core/itpt_if.sv]
// Valid/ready channel interfaces for formatter requests and characters.
`timescale 1ns / 1ps
interface itpt_in_if;
  import itpt_pkg::*;
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;
  logic [1:0]       base_code;
  logic [5:0]       field_width;
  logic [5:0]       min_digits;
  logic [6:0]       option_bits;

  modport source (output valid, number, base_code, field_width, min_digits, option_bits,
                  input ready);
  modport sink (input valid, number, base_code, field_width, min_digits, option_bits,
                output ready);
endinterface

interface itpt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

[rtl/core/itpt_dabble.sv]
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
`timescale 1ns / 1ps
module itpt_dabble (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [itpt_pkg::NUM_W-1:0]     bin,
  output logic                           busy,
  output logic [itpt_pkg::DIG_REG_W-1:0] bcd
);
  import itpt_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]     bin_r, bin_nxt;
  logic [DIG_REG_W-1:0] bcd_r, bcd_nxt, adj;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;

  // Add three to every nibble of five or more before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      bin_nxt  = bin;
      bcd_nxt  = '0;
    end else if (busy_r) begin
      bcd_nxt = {adj[DIG_REG_W-2:0], bin_r[NUM_W-1]};
      bin_nxt = bin_r << 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy = busy_r;
  assign bcd  = bcd_r;

endmodule

[rtl/core/itpt_digits.sv]
// Digit shift register: loads the magnitude in digits, shifts out one digit per cycle on shift.
`timescale 1ns / 1ps
module itpt_digits (
  input  logic                           clk,
  input  logic                           rst_n,
  input  itpt_pkg::dig_cmd_t             cmd,
  input  itpt_pkg::base_t                base,
  input  logic [itpt_pkg::NUM_W-1:0]     mag,
  input  logic [itpt_pkg::DIG_REG_W-1:0] bcd,
  output logic [3:0]                     top_digit,
  output itpt_pkg::dcnt_t                remaining
);
  import itpt_pkg::*;

  localparam int FILL_W = DIG_REG_W - NUM_W;

  logic [DIG_REG_W-1:0] dig_r, dig_nxt;
  dcnt_t                rem_r, rem_nxt;

  always_comb begin
    dig_nxt = dig_r;
    rem_nxt = rem_r;
    if (cmd.load) begin
      unique case (base)
        BASE_BIN: begin
          dig_nxt = {mag, {FILL_W{1'b0}}};
          rem_nxt = DIGS_BIN;
        end
        BASE_OCT: begin
          // Pad to 33 bits so the value splits into eleven 3-bit digits.
          dig_nxt = {1'b0, mag, {(FILL_W - 1){1'b0}}};
          rem_nxt = DIGS_OCT;
        end
        BASE_DEC: begin
          dig_nxt = bcd;
          rem_nxt = DIGS_DEC;
        end
        BASE_HEX: begin
          dig_nxt = {mag, {FILL_W{1'b0}}};
          rem_nxt = DIGS_HEX;
        end
      endcase
    end else if (cmd.shift) begin
      unique case (base)
        BASE_BIN: dig_nxt = dig_r << 1;
        BASE_OCT: dig_nxt = dig_r << 3;
        BASE_DEC: dig_nxt = dig_r << 4;
        BASE_HEX: dig_nxt = dig_r << 4;
      endcase
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_comb begin
    unique case (base)
      BASE_BIN: top_digit = {3'b000, dig_r[DIG_REG_W-1]};
      BASE_OCT: top_digit = {1'b0, dig_r[DIG_REG_W-1 -: 3]};
      BASE_DEC: top_digit = dig_r[DIG_REG_W-1 -: 4];
      BASE_HEX: top_digit = dig_r[DIG_REG_W-1 -: 4];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign remaining = rem_r;

endmodule

[rtl/core/integer_to_padded_text.sv]
// Top level of the integer formatter: request capture, character sequencer, output register.
//
// Usage: a number with base, field width, minimum digit count and options enters on in_ch
// as one transaction; its formatted ASCII text leaves on out_ch, one character per
// transaction, the final character flagged by last_char. Every number gives at least one
// character and at most MAX_FIELD_WIDTH.
// Flow per number: decimal values pass through the serial BCD converter (one bit per
// cycle), other bases skip it. Leading zero digits are then dropped one per cycle (up to
// 31 for binary, 10 for octal, 9 for decimal, 7 for hex), a sizing step computes the
// padding, and the characters follow at one per cycle while out_ch.ready allows; each text
// segment but the prefix closes with a step that emits nothing. in_ch.ready is high only
// while the sequencer is idle; the next number can be taken while the final character
// still sits in the output register.
// Stall: when out_ch.ready is low the output register holds its character and the
// sequencer waits; no character is lost or repeated.
// Reset (rst_n low, synchronous): the sequencer returns to idle and the output register
// empties; a number in progress is dropped.
`timescale 1ns / 1ps
`include "integer_to_padded_text_defines.svh"
module integer_to_padded_text #(
  parameter int MAX_FIELD_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  itpt_in_if.sink           in_ch,
  itpt_out_if.source        out_ch
);
  import itpt_pkg::*;

  // Character count width; the count must hold MAX_FIELD_WIDTH itself.
  localparam int CW = $clog2(MAX_FIELD_WIDTH + 1);
  localparam logic [CW-1:0] WIDTH_CAP = CW'(MAX_FIELD_WIDTH);
  localparam logic [CW-1:0] PREC_CAP  = CW'(MAX_FIELD_WIDTH - 3);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CONV  = 12'b0000_0000_0010,
    S_SCAN  = 12'b0000_0000_0100,
    S_SIZE  = 12'b0000_0000_1000,
    S_LSP   = 12'b0000_0001_0000,
    S_SIGN  = 12'b0000_0010_0000,
    S_PFX0  = 12'b0000_0100_0000,
    S_PFXL  = 12'b0000_1000_0000,
    S_ZPAD  = 12'b0001_0000_0000,
    S_PZERO = 12'b0010_0000_0000,
    S_DIG   = 12'b0100_0000_0000,
    S_TSP   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Captured request.
  base_t            base_r;
  logic             zero_r, left_r, lower_r, pfx_r;
  char_t            sign_ch_r;
  logic             sgn_r, sgn_nxt;
  logic [CW-1:0]    width_r, prec_r;
  logic [NUM_W-1:0] mag_r;

  // Segment counters.
  logic [CW-1:0] pad_r, pad_nxt;
  logic [CW-1:0] pz_r, pz_nxt;
  logic [CW-1:0] tot_r, tot_nxt;

  // Output register.
  logic  out_valid_r;
  char_t out_char_r;
  logic  out_last_r;

  logic             in_acc;
  logic             neg_in;
  logic [NUM_W-1:0] mag_in;
  logic             sgn_in;
  char_t            sign_ch_in;
  logic [CW-1:0]    fw_ext, md_ext;

  logic                 dab_start, dab_busy;
  logic [DIG_REG_W-1:0] dab_bcd;
  dig_cmd_t             dig_cmd;
  logic [3:0]           top_digit;
  dcnt_t                dig_rem;

  logic          out_can, emit;
  char_t         emit_char;
  logic [CW-1:0] nd_ext, prec_eff, fixed_len;
  logic [CW:0]   pad_diff;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);

  // Sign and magnitude of the incoming number; a negative value prints its magnitude.
  assign neg_in = in_ch.option_bits[OPT_SIGNED] && in_ch.number[NUM_W-1];
  assign mag_in = neg_in ? (NUM_W'(0) - in_ch.number) : in_ch.number;
  assign sgn_in = in_ch.option_bits[OPT_SIGNED] &&
                  (neg_in || in_ch.option_bits[OPT_PLUS] || in_ch.option_bits[OPT_SPACE]);
  assign sign_ch_in = neg_in ? CH_MINUS :
                      (in_ch.option_bits[OPT_PLUS] ? CH_PLUS : CH_SPACE);

  // Widen the field width and the digit minimum; the clamp is applied on capture.
  assign fw_ext = CW'(in_ch.field_width);
  assign md_ext = CW'(in_ch.min_digits);

  // Start the BCD converter straight from the input for decimal requests.
  assign dab_start = in_acc && (in_ch.base_code == BASE_DEC);

  itpt_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .bin   (mag_in),
    .busy  (dab_busy),
    .bcd   (dab_bcd)
  );

  itpt_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dig_cmd),
    .base      (base_r),
    .mag       (mag_r),
    .bcd       (dab_bcd),
    .top_digit (top_digit),
    .remaining (dig_rem)
  );

  // Sizing: digits shown, then padding against the field width.
  assign nd_ext    = CW'(dig_rem);
  assign prec_eff  = (prec_r < nd_ext) ? nd_ext : prec_r;
  assign fixed_len = prec_eff + CW'(sgn_r) + (pfx_r ? CW'(2) : CW'(0));
  assign pad_diff  = {1'b0, width_r} - {1'b0, fixed_len};

  // A character may enter the output register when it is empty or being drained.
  assign out_can = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    pad_nxt   = pad_r;
    pz_nxt    = pz_r;
    tot_nxt   = tot_r;
    sgn_nxt   = sgn_r;
    dig_cmd   = '0;
    emit      = 1'b0;
    emit_char = CH_SPACE;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // Wait for the converter on decimal; other bases load at once.
        if (!dab_busy) begin
          dig_cmd.load = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // Drop leading zero digits, keep at least one.
        if (top_digit == 4'd0 && dig_rem > dcnt_t'(1)) begin
          dig_cmd.shift = 1'b1;
        end else begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        pad_nxt   = pad_diff[CW] ? '0 : pad_diff[CW-1:0];
        pz_nxt    = prec_eff - nd_ext;
        tot_nxt   = fixed_len + (pad_diff[CW] ? '0 : pad_diff[CW-1:0]);
        state_nxt = S_LSP;
      end
      S_LSP: begin
        if (!zero_r && !left_r && pad_r != '0) begin
          if (out_can) begin
            emit      = 1'b1;
            emit_char = CH_SPACE;
            pad_nxt   = pad_r - 1'b1;
          end
        end else begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        if (sgn_r) begin
          if (out_can) begin
            emit      = 1'b1;
            emit_char = sign_ch_r;
            sgn_nxt   = 1'b0;
          end
        end else begin
          state_nxt = S_PFX0;
        end
      end
      S_PFX0: begin
        if (!pfx_r) begin
          state_nxt = S_ZPAD;
        end else if (out_can) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          state_nxt = S_PFXL;
        end
      end
      S_PFXL: begin
        if (out_can) begin
          emit      = 1'b1;
          emit_char = prefix_char(base_r);
          state_nxt = S_ZPAD;
        end
      end
      S_ZPAD: begin
        if (zero_r && pad_r != '0) begin
          if (out_can) begin
            emit      = 1'b1;
            emit_char = CH_ZERO;
            pad_nxt   = pad_r - 1'b1;
          end
        end else begin
          state_nxt = S_PZERO;
        end
      end
      S_PZERO: begin
        if (pz_r != '0) begin
          if (out_can) begin
            emit      = 1'b1;
            emit_char = CH_ZERO;
            pz_nxt    = pz_r - 1'b1;
          end
        end else begin
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        // Emit digits most significant first, advancing the shift register.
        if (dig_rem != '0) begin
          if (out_can) begin
            emit          = 1'b1;
            emit_char     = digit_char(top_digit, lower_r);
            dig_cmd.shift = 1'b1;
          end
        end else begin
          state_nxt = S_TSP;
        end
      end
      S_TSP: begin
        if (left_r && pad_r != '0) begin
          if (out_can) begin
            emit      = 1'b1;
            emit_char = CH_SPACE;
            pad_nxt   = pad_r - 1'b1;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (emit) begin
      tot_nxt = tot_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept, hold otherwise; sgn_r clears once its sign is sent.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r    <= in_ch.base_code;
      zero_r    <= in_ch.option_bits[OPT_ZERO] && !in_ch.option_bits[OPT_LEFT];
      left_r    <= in_ch.option_bits[OPT_LEFT];
      lower_r   <= in_ch.option_bits[OPT_LOWER];
      pfx_r     <= in_ch.option_bits[OPT_PREFIX] && (in_ch.base_code != BASE_DEC);
      sign_ch_r <= sign_ch_in;
      sgn_r     <= sgn_in;
      width_r   <= (fw_ext > WIDTH_CAP) ? WIDTH_CAP : fw_ext;
      prec_r    <= (md_ext > PREC_CAP) ? PREC_CAP : md_ext;
      mag_r     <= mag_in;
    end else begin
      sgn_r <= sgn_nxt;
    end
    pad_r <= pad_nxt;
    pz_r  <= pz_nxt;
    tot_r <= tot_nxt;
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= (tot_r == CW'(1));
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last_char = out_last_r;

  `ITPT_ASSERT_SAME(a_emit_within_total, emit, tot_r != '0, "character beyond sized total")
  `ITPT_ASSERT_SAME(a_done_exact_total, (state_r == S_TSP) && (state_nxt == S_IDLE),
                    tot_r == '0, "number finished with characters owed")
  `ITPT_ASSERT_NEXT(a_dec_starts_conv, in_acc && (in_ch.base_code == BASE_DEC),
                    dab_busy, "decimal transaction did not start conversion")

endmodule
